@@ rtl/brb_pkg.sv @@
package brb_pkg;

    // storage geometry
    localparam int DEPTH    = 1024;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int MAX_PEEK = 64;
    localparam int PEEK_W   = $clog2(MAX_PEEK + 1);

    // field widths
    localparam int REQ_W    = 2;
    localparam int DATA_W   = 8;
    localparam int SIZE_W   = 11;
    localparam int LEVEL_W  = 10;
    localparam int STATUS_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT     = 2'd0,
        REQ_PEEK    = 2'd1,
        REQ_DISCARD = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_EMPTY  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_PEEK = 2'b10
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0]  out_data;
        logic [LEVEL_W-1:0] level;
        t_status            status;
        logic               last;
    } t_result;

endpackage

@@ rtl/brb_ifs.sv @@
interface brb_req_if;
    logic                       valid;
    logic                       ready;
    logic [brb_pkg::REQ_W-1:0]  req_type;
    logic [brb_pkg::DATA_W-1:0] data;
    logic [brb_pkg::SIZE_W-1:0] count;
    logic                       burst_first;

    modport source (output valid, req_type, data, count, burst_first, input ready);
    modport sink   (input valid, req_type, data, count, burst_first, output ready);
endinterface

interface brb_res_if;
    logic                         valid;
    logic                         ready;
    logic [brb_pkg::DATA_W-1:0]   out_data;
    logic [brb_pkg::LEVEL_W-1:0]  level;
    logic [brb_pkg::STATUS_W-1:0] status;
    logic                         last;

    modport source (output valid, out_data, level, status, last, input ready);
    modport sink   (input valid, out_data, level, status, last, output ready);
endinterface

@@ rtl/brb_ram.sv @@
module brb_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/byte_ring_buffer_peek_discard.sv @@
// circular byte fifo with all-or-nothing put bursts, peek and discard. bytes live in
// a single-port-write, registered-read ram of brb_pkg::DEPTH entries; the read and
// write pointers wrap at buf_size, one slot always stays free, so at most
// buf_size - 1 bytes are held. put, discard and clear each give one result
// transaction; a peek of n bytes (n = min(count, level, 64)) streams one byte per
// cycle, while the output is not stalled, from the ram read port and keeps the
// request channel closed until its last byte leaves the read data stage; an empty or
// zero-length peek gives a single result. a buf_size write empties the store and
// cancels any burst; there is no clearing pass after reset, and ram contents are
// undefined until written. every result carries the fill level after its request.
module byte_ring_buffer_peek_discard (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [brb_pkg::SIZE_W-1:0] i_cfg_wdata,
    brb_req_if.sink                    i_in,
    brb_res_if.source                  o_out
);

    // registers
    brb_pkg::t_state             r_state, n_state;
    logic [brb_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [brb_pkg::PTR_W-1:0]   r_wp, n_wp;
    logic [brb_pkg::PTR_W-1:0]   r_rp, n_rp;
    logic [brb_pkg::PTR_W-1:0]   r_level, n_level;
    logic                        r_acc, n_acc;       // burst accepted
    logic [brb_pkg::PTR_W-1:0]   r_left, n_left;     // bytes still owed to the burst
    logic [brb_pkg::PTR_W-1:0]   r_pk_ptr, n_pk_ptr; // next peek address
    logic [brb_pkg::PEEK_W-1:0]  r_pk_left, n_pk_left;
    logic                        r_rd_pend;          // ram read data waiting for output
    logic                        r_rd_last;
    logic                        r_out_valid;
    brb_pkg::t_result            r_out;

    // handshake
    logic out_free;
    logic rd_move;
    logic in_ready;
    logic in_fire;
    logic rd_issue;

    // per-request arithmetic
    logic [brb_pkg::SIZE_W-1:0]  room;
    logic [brb_pkg::PTR_W-1:0]   wp_inc;
    logic [brb_pkg::PTR_W-1:0]   pk_inc;
    logic [brb_pkg::PTR_W-1:0]   lvl_cap;    // min(count, level)
    logic [brb_pkg::PEEK_W-1:0]  pk_n;
    logic [brb_pkg::SIZE_W-1:0]  disc_sum;
    logic [brb_pkg::SIZE_W-1:0]  cfg_size;

    // result and ram control
    brb_pkg::t_result            res;
    logic                        res_load;
    logic                        mem_we;
    logic [brb_pkg::DATA_W-1:0]  mem_rdata;

    assign out_free = !r_out_valid || o_out.ready;
    assign rd_move  = r_rd_pend && out_free;
    // one request at a time: closed while a peek is streaming or a result cannot move
    assign in_ready = (r_state == brb_pkg::S_IDLE) && !r_rd_pend && out_free;
    assign in_fire  = i_in.valid && in_ready;
    // next peek read only when the read data stage is free or emptying
    assign rd_issue = (r_state == brb_pkg::S_PEEK) && (!r_rd_pend || rd_move);

    assign i_in.ready = in_ready;

    // free space; size always exceeds level so this never wraps
    assign room = r_size - brb_pkg::SIZE_W'(1) - brb_pkg::SIZE_W'(r_level);

    // pointer increments wrapping at buf_size
    assign wp_inc = (brb_pkg::SIZE_W'(r_wp) + brb_pkg::SIZE_W'(1) == r_size)
                    ? '0 : r_wp + 1'b1;
    assign pk_inc = (brb_pkg::SIZE_W'(r_pk_ptr) + brb_pkg::SIZE_W'(1) == r_size)
                    ? '0 : r_pk_ptr + 1'b1;

    // peek length and discard length share the clamp to the fill level
    assign lvl_cap = (i_in.count < brb_pkg::SIZE_W'(r_level))
                     ? i_in.count[brb_pkg::PTR_W-1:0] : r_level;
    assign pk_n    = (lvl_cap > brb_pkg::PTR_W'(brb_pkg::MAX_PEEK))
                     ? brb_pkg::PEEK_W'(brb_pkg::MAX_PEEK) : lvl_cap[brb_pkg::PEEK_W-1:0];
    assign disc_sum = brb_pkg::SIZE_W'(r_rp) + brb_pkg::SIZE_W'(lvl_cap);

    // saturate the written size to the usable range
    assign cfg_size = (i_cfg_wdata < brb_pkg::SIZE_MIN) ? brb_pkg::SIZE_MIN :
                      (i_cfg_wdata > brb_pkg::SIZE_MAX) ? brb_pkg::SIZE_MAX : i_cfg_wdata;

    always_comb begin
        n_state   = r_state;
        n_size    = r_size;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_level   = r_level;
        n_acc     = r_acc;
        n_left    = r_left;
        n_pk_ptr  = r_pk_ptr;
        n_pk_left = r_pk_left;
        mem_we    = 1'b0;
        res_load  = 1'b0;
        res          = '0;
        res.status   = brb_pkg::STAT_OK;
        res.level    = brb_pkg::LEVEL_W'(r_level);
        res.last     = 1'b1;

        if (i_cfg_we) begin
            // new size empties the store and drops any burst
            n_size  = cfg_size;
            n_wp    = '0;
            n_rp    = '0;
            n_level = '0;
            n_acc   = 1'b0;
            n_left  = '0;
        end else if (in_fire) begin
            case (i_in.req_type)
                brb_pkg::REQ_PUT: begin
                    res_load = 1'b1;
                    // first byte: fit check for the whole burst
                    if (i_in.burst_first) begin
                        if (i_in.count <= room) begin
                            n_acc  = 1'b1;
                            n_left = i_in.count[brb_pkg::PTR_W-1:0];
                        end else begin
                            n_acc      = 1'b0;
                            n_left     = '0;
                            res.status = brb_pkg::STAT_REJECT;
                        end
                    end
                    if (res.status == brb_pkg::STAT_OK) begin
                        if (n_acc && (n_left != '0)) begin
                            mem_we  = 1'b1;
                            n_wp    = wp_inc;
                            n_left  = n_left - 1'b1;
                            n_level = r_level + 1'b1;
                        end else if (!i_in.burst_first) begin
                            // stray byte outside an accepted burst
                            res.status = brb_pkg::STAT_REJECT;
                        end
                        if (n_left == '0) begin
                            n_acc = 1'b0;
                        end
                    end
                    res.level = brb_pkg::LEVEL_W'(n_level);
                end
                brb_pkg::REQ_PEEK: begin
                    if (r_level == '0) begin
                        res_load   = 1'b1;
                        res.status = brb_pkg::STAT_EMPTY;
                    end else if (pk_n == '0) begin
                        res_load = 1'b1;
                    end else begin
                        // stream from the read pointer, results come from the ram
                        n_state   = brb_pkg::S_PEEK;
                        n_pk_ptr  = r_rp;
                        n_pk_left = pk_n;
                    end
                end
                brb_pkg::REQ_DISCARD: begin
                    res_load = 1'b1;
                    n_rp     = (disc_sum >= r_size)
                               ? brb_pkg::PTR_W'(disc_sum - r_size)
                               : disc_sum[brb_pkg::PTR_W-1:0];
                    n_level   = r_level - lvl_cap;
                    res.level = brb_pkg::LEVEL_W'(n_level);
                end
                brb_pkg::REQ_CLEAR: begin
                    res_load  = 1'b1;
                    n_wp      = '0;
                    n_rp      = '0;
                    n_level   = '0;
                    n_acc     = 1'b0;
                    n_left    = '0;
                    res.level = '0;
                end
                default: begin
                    res_load = 1'b0;
                end
            endcase
        end else if (rd_issue) begin
            n_pk_ptr  = pk_inc;
            n_pk_left = r_pk_left - 1'b1;
            if (r_pk_left == brb_pkg::PEEK_W'(1)) begin
                n_state = brb_pkg::S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= brb_pkg::S_IDLE;
            r_size    <= brb_pkg::SIZE_MAX;
            r_wp      <= '0;
            r_rp      <= '0;
            r_level   <= '0;
            r_acc     <= 1'b0;
            r_left    <= '0;
            r_pk_ptr  <= '0;
            r_pk_left <= '0;
        end else begin
            r_state   <= n_state;
            r_size    <= n_size;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_level   <= n_level;
            r_acc     <= n_acc;
            r_left    <= n_left;
            r_pk_ptr  <= n_pk_ptr;
            r_pk_left <= n_pk_left;
        end
    end

    // read data stage: valid while the ram output holds an unsent peek byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else if (rd_issue) begin
            r_rd_pend <= 1'b1;
        end else if (rd_move) begin
            r_rd_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_last <= (r_pk_left == brb_pkg::PEEK_W'(1));
        end
    end

    // output register, parts the result side from the request side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load || rd_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end else if (rd_move) begin
            r_out.out_data <= mem_rdata;
            r_out.level    <= brb_pkg::LEVEL_W'(r_level);
            r_out.status   <= brb_pkg::STAT_OK;
            r_out.last     <= r_rd_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_data = r_out.out_data;
    assign o_out.level    = r_out.level;
    assign o_out.status   = r_out.status;
    assign o_out.last     = r_out.last;

    // byte store; puts and peeks never overlap, so no forwarding is needed
    brb_ram #(
        .ADDR_W (brb_pkg::PTR_W),
        .DATA_W (brb_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (i_in.data),
        .i_re    (rd_issue),
        .i_raddr (r_pk_ptr),
        .o_rdata (mem_rdata)
    );

endmodule

@@ rtl/brb_checker.sv @@
module brb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [brb_pkg::DATA_W-1:0]   i_out_data,
    input logic [brb_pkg::LEVEL_W-1:0]  i_out_level,
    input logic [brb_pkg::STATUS_W-1:0] i_out_status,
    input logic                         i_out_last
);

    // an empty peek reports a zero level and closes its transaction
    a_empty_peek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == brb_pkg::STAT_EMPTY)
        |-> (i_out_level == '0 && i_out_last))
        else $error("empty peek result with non-zero level or not last");

    // only peek bytes carry data, and they never carry an error
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data != '0) |-> (i_out_status == brb_pkg::STAT_OK))
        else $error("data byte with error status");

    // no new request while a peek stream is still open
    a_no_req_mid_peek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !(i_in_valid && i_in_ready))
        else $error("request accepted in the middle of a peek");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_out_data) && $stable(i_out_level)
             && $stable(i_out_status) && $stable(i_out_last)))
        else $error("stalled result changed");

    // reset empties the output
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind byte_ring_buffer_peek_discard brb_checker u_brb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_data   (o_out.out_data),
    .i_out_level  (o_out.level),
    .i_out_status (o_out.status),
    .i_out_last   (o_out.last)
);
